/* design/stack_accumulator_vm_execute_assert.svh */
// Assertion macros for the stack accumulator machine.
`ifndef STACK_ACCUMULATOR_VM_EXECUTE_ASSERT_SVH
`define STACK_ACCUMULATOR_VM_EXECUTE_ASSERT_SVH
`ifndef SYNTH
`define SAVM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SAVM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SAVM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SAVM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* design/savm_pkg.sv */
package savm_pkg;

   localparam int StackDepth = 1024;
   localparam int PcWidth    = 16;
   localparam int FrameBits  = 12;
   localparam int WordBits   = 32;
   localparam int AddrBits   = $clog2(StackDepth);
   localparam int SpBits     = $clog2(StackDepth + 1);

   typedef enum logic [4:0] {
      OP_ADD   = 5'd0,
      OP_SUB   = 5'd1,
      OP_MUL   = 5'd2,
      OP_DIV   = 5'd3,
      OP_LT    = 5'd4,
      OP_LTE   = 5'd5,
      OP_GT    = 5'd6,
      OP_GTE   = 5'd7,
      OP_EQ    = 5'd8,
      OP_NEQ   = 5'd9,
      OP_LDC   = 5'd10,
      OP_LD    = 5'd11,
      OP_ABSLD = 5'd12,
      OP_ST    = 5'd13,
      OP_ABSST = 5'd14,
      OP_PUSH  = 5'd15,
      OP_POP   = 5'd16,
      OP_JMP   = 5'd17,
      OP_JZ    = 5'd18,
      OP_CALL  = 5'd19,
      OP_RET   = 5'd20,
      OP_ADDR  = 5'd21,
      OP_IN    = 5'd22,
      OP_OUT   = 5'd23
   } op_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_BAD_OP = 3'd1,
      ST_EMPTY  = 3'd2,
      ST_FULL   = 3'd3,
      ST_RANGE  = 3'd4,
      ST_DIV0   = 3'd5
   } status_type;

   typedef struct packed {
      logic                wr_en;
      logic [AddrBits-1:0] wr_addr;
      logic [WordBits-1:0] wr_data;
      logic [AddrBits-1:0] rd_addr;
   } mem_req_type;

endpackage

/* design/stack_accumulator_vm_execute.sv */
// Executes one instruction of an accumulator-plus-stack machine per transfer. An instruction
// is taken only while the block is idle; it then reads the stack top from the stack memory,
// which has one write port and one read port and whose read data is registered, executes, and
// holds the response until it is taken. Most instructions pass through S_TOP and S_EXEC to
// S_DONE; LD, ABSLD, CALL and RET add a state (S_LOAD, S_CALL2 or S_RETFB) because they need a
// second memory access; DIV waits in S_DIV for the one-bit-per-cycle divider. After a response
// transfer the block returns to idle before it takes the next request.
`include "stack_accumulator_vm_execute_assert.svh"

module stack_accumulator_vm_execute (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [4:0]                           req_cmd,
   input  logic signed [31:0]                   req_operand,
   input  logic signed [31:0]                   req_in_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [savm_pkg::PcWidth-1:0]         rsp_next_pc,
   output logic signed [31:0]                   rsp_acc_value,
   output logic                                 rsp_out_valid,
   output logic signed [31:0]                   rsp_out_value,
   output logic [2:0]                           rsp_status
);

   localparam int W  = savm_pkg::WordBits;
   localparam int PW = savm_pkg::PcWidth;
   localparam int FB = savm_pkg::FrameBits;
   localparam int AB = savm_pkg::AddrBits;
   localparam int SB = savm_pkg::SpBits;

   typedef enum logic [2:0] {
      S_IDLE, S_TOP, S_EXEC, S_LOAD, S_RETFB, S_DIV, S_CALL2, S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [W-1:0]           acc_ff, acc_in;
   logic [PW-1:0]          pc_ff, pc_in;
   logic [FB-1:0]          fb_ff, fb_in;
   logic [SB-1:0]          sp_ff, sp_in;
   logic                   outv_ff, outv_in;
   savm_pkg::status_type   status_ff, status_in;
   logic [4:0]             cmd_ff;
   logic [W-1:0]           operand_ff;
   logic [W-1:0]           in_value_ff;

   savm_pkg::mem_req_type  mem_req;
   logic [W-1:0]           rd_data;
   logic                   div_start;
   logic                   div_done;
   logic [W-1:0]           div_quotient;

   logic [PW-1:0]          pc_plus1;
   logic [PW-1:0]          pc_jump;
   logic [W+1:0]           idx;
   logic                   idx_ok;
   logic                   needs_top;
   logic                   top_lt;
   logic                   top_eq;

   savm_stack u_stack (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   savm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data),
      .divisor  (acc_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign pc_plus1 = pc_ff + 1'b1;
   assign pc_jump  = pc_ff + PW'(operand_ff);
   assign top_lt   = $signed(rd_data) < $signed(acc_ff);
   assign top_eq   = rd_data == acc_ff;
   assign needs_top = (cmd_ff <= savm_pkg::OP_NEQ) || (cmd_ff == savm_pkg::OP_ST) ||
                      (cmd_ff == savm_pkg::OP_ABSST) || (cmd_ff == savm_pkg::OP_POP);

   always_comb begin
      if ((cmd_ff == savm_pkg::OP_LD) || (cmd_ff == savm_pkg::OP_ST)) begin
         idx = {{(W + 2 - FB){fb_ff[FB-1]}}, fb_ff} - {{2{acc_ff[W-1]}}, acc_ff};
      end else begin
         idx = {{2{acc_ff[W-1]}}, acc_ff};
      end
      idx_ok = !idx[W+1] && (idx < (W + 2)'(sp_ff));
   end

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      pc_in     = pc_ff;
      fb_in     = fb_ff;
      sp_in     = sp_ff;
      outv_in   = outv_ff;
      status_in = status_ff;
      div_start = 1'b0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = AB'(sp_ff);
      mem_req.wr_data = acc_ff;
      mem_req.rd_addr = AB'(sp_ff - 1'b1);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in  = S_DONE;
            status_in = savm_pkg::ST_OK;
            outv_in   = 1'b0;
            pc_in     = pc_plus1;
            if (needs_top && (sp_ff == '0)) begin
               status_in = savm_pkg::ST_EMPTY;
            end else begin
               unique case (cmd_ff)
                  savm_pkg::OP_ADD: acc_in = rd_data + acc_ff;
                  savm_pkg::OP_SUB: acc_in = rd_data - acc_ff;
                  savm_pkg::OP_MUL: acc_in = rd_data * acc_ff;
                  savm_pkg::OP_DIV: begin
                     if (acc_ff == '0) begin
                        status_in = savm_pkg::ST_DIV0;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  savm_pkg::OP_LT:  acc_in = W'(top_lt);
                  savm_pkg::OP_LTE: acc_in = W'(top_lt || top_eq);
                  savm_pkg::OP_GT:  acc_in = W'(!top_lt && !top_eq);
                  savm_pkg::OP_GTE: acc_in = W'(!top_lt);
                  savm_pkg::OP_EQ:  acc_in = W'(top_eq);
                  savm_pkg::OP_NEQ: acc_in = W'(!top_eq);
                  savm_pkg::OP_LDC: acc_in = operand_ff;
                  savm_pkg::OP_LD, savm_pkg::OP_ABSLD: begin
                     if (!idx_ok) begin
                        status_in = savm_pkg::ST_RANGE;
                     end else begin
                        mem_req.rd_addr = idx[AB-1:0];
                        state_in        = S_LOAD;
                     end
                  end
                  savm_pkg::OP_ST, savm_pkg::OP_ABSST: begin
                     if (!idx_ok) begin
                        status_in = savm_pkg::ST_RANGE;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = idx[AB-1:0];
                        mem_req.wr_data = rd_data;
                     end
                  end
                  savm_pkg::OP_PUSH: begin
                     if (sp_ff >= SB'(savm_pkg::StackDepth)) begin
                        status_in = savm_pkg::ST_FULL;
                     end else begin
                        mem_req.wr_en = 1'b1;
                        sp_in         = sp_ff + 1'b1;
                     end
                  end
                  savm_pkg::OP_POP: sp_in = sp_ff - 1'b1;
                  savm_pkg::OP_JMP: pc_in = pc_jump;
                  savm_pkg::OP_JZ: begin
                     if (acc_ff == '0) begin
                        pc_in = pc_jump;
                     end
                  end
                  savm_pkg::OP_CALL: begin
                     if (((SB + 1)'(sp_ff) + 2'd2) > (SB + 1)'(savm_pkg::StackDepth)) begin
                        status_in = savm_pkg::ST_FULL;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_data = W'($signed(fb_ff));
                        fb_in           = FB'(W'(sp_ff) - 1'b1);
                        pc_in           = pc_ff;
                        state_in        = S_CALL2;
                     end
                  end
                  savm_pkg::OP_RET: begin
                     if (sp_ff < SB'(2)) begin
                        status_in = savm_pkg::ST_EMPTY;
                     end else begin
                        pc_in           = PW'(rd_data) + 1'b1;
                        mem_req.rd_addr = AB'(sp_ff - SB'(2));
                        state_in        = S_RETFB;
                     end
                  end
                  savm_pkg::OP_ADDR: acc_in = W'(sp_ff) - operand_ff;
                  savm_pkg::OP_IN:   acc_in = in_value_ff;
                  savm_pkg::OP_OUT:  outv_in = 1'b1;
                  default: status_in = savm_pkg::ST_BAD_OP;
               endcase
            end
            if (status_in != savm_pkg::ST_OK) begin
               pc_in    = pc_ff;
               acc_in   = acc_ff;
               state_in = S_DONE;
            end
         end
         S_LOAD: begin
            acc_in   = rd_data;
            state_in = S_DONE;
         end
         S_RETFB: begin
            fb_in    = rd_data[FB-1:0];
            sp_in    = sp_ff - SB'(2);
            state_in = S_DONE;
         end
         S_DIV: begin
            if (div_done) begin
               acc_in   = div_quotient;
               state_in = S_DONE;
            end
         end
         S_CALL2: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = AB'(sp_ff + 1'b1);
            mem_req.wr_data = W'(pc_ff);
            sp_in           = sp_ff + SB'(2);
            pc_in           = pc_jump;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         acc_ff    <= '0;
         pc_ff     <= '0;
         fb_ff     <= '0;
         sp_ff     <= '0;
         outv_ff   <= 1'b0;
         status_ff <= savm_pkg::ST_OK;
      end else begin
         state_ff  <= state_in;
         acc_ff    <= acc_in;
         pc_ff     <= pc_in;
         fb_ff     <= fb_in;
         sp_ff     <= sp_in;
         outv_ff   <= outv_in;
         status_ff <= status_in;
      end
      if ((state_ff == S_IDLE) && req_valid) begin
         cmd_ff      <= req_cmd;
         operand_ff  <= req_operand;
         in_value_ff <= req_in_value;
      end
   end

   assign req_stall     = state_ff != S_IDLE;
   assign rsp_valid     = state_ff == S_DONE;
   assign rsp_next_pc   = pc_ff;
   assign rsp_acc_value = acc_ff;
   assign rsp_out_valid = outv_ff;
   assign rsp_out_value = outv_ff ? acc_ff : '0;
   assign rsp_status    = status_ff;

   `SAVM_ASSERT_NXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall && !rsp_valid, "no start")
   `SAVM_ASSERT_NXT(a_rsp_once, clock, reset, rsp_valid && !rsp_stall, !rsp_valid, "response repeated")
   `SAVM_ASSERT_IMP(a_err_no_out, clock, reset, rsp_valid && (rsp_status != 3'd0), !rsp_out_valid, "bad out")
   `SAVM_ASSERT_IMP(a_sp_bound, clock, reset, 1'b1, sp_ff <= SB'(savm_pkg::StackDepth), "sp too large")

endmodule

/* design/savm_stack.sv */
module savm_stack (
   input  logic                                  clock,
   input  savm_pkg::mem_req_type                 mem_req,
   output logic [savm_pkg::WordBits-1:0]         rd_data
);

   logic [savm_pkg::WordBits-1:0] mem [savm_pkg::StackDepth];
   logic [savm_pkg::WordBits-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/savm_div.sv */
module savm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [savm_pkg::WordBits-1:0] dividend,
   input  logic [savm_pkg::WordBits-1:0] divisor,
   output logic                          done,
   output logic [savm_pkg::WordBits-1:0] quotient
);

   localparam int W  = savm_pkg::WordBits;
   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic          neg_ff, neg_in;
   logic [W:0]    rem_sh;
   logic [W:0]    diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      neg_in   = neg_ff;
      rem_sh   = {rem_ff[W-1:0], quo_ff[W-1]};
      diff     = rem_sh - {1'b0, dvs_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend[W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in   = divisor[W-1] ? (~divisor + 1'b1) : divisor;
         neg_in   = dividend[W-1] ^ divisor[W-1];
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff;
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule
